// ===== src/dsdp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsdp_pkg
// Shared types, constants and a helper function of the DSD to DoP packer.
// ----------------------------------------------------------------------------
package dsdp_pkg;

   // Default, reset and minimum values of the configuration.
   localparam int MAX_BLOCK_BYTES_DEF = 8192;
   localparam int BLOCK_BYTES_RESET   = 8192;
   localparam int BLOCK_BYTES_MIN     = 4;

   // Configuration port geometry and register indexes.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERLEAVED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = 1'd1;

   // DoP markers.
   localparam logic [7:0] MARKER_BASE = 8'h05;
   localparam logic [7:0] MARKER_FLIP = 8'hFA;

   // Depth of the frame pair queue between the front and the back.
   localparam int PAIR_QUEUE_DEPTH = 4;

   // One left/right frame pair as classified by the front end.
   typedef struct packed {
      logic       planar;   // left bytes come from the store read data
      logic       marker;   // 1 selects the flipped marker
      logic [7:0] left0;
      logic [7:0] left1;
      logic [7:0] right0;
      logic [7:0] right1;
      logic       last;
   } dsdp_pair_type;

   function automatic logic [7:0] rev8(input logic [7:0] b);
      logic [7:0] r;
      r = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
      r = ((r & 8'hCC) >> 2) | ((r & 8'h33) << 2);
      r = ((r & 8'hAA) >> 1) | ((r & 8'h55) << 1);
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/dsdp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsdp_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module dsdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

// ===== src/dsdp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsdp_front
// Accepts DSD bytes, tracks the block position and marker, fills the planar
// left-half store and hands each completed frame pair to the back end.
// ----------------------------------------------------------------------------
module dsdp_front
   import dsdp_pkg::*;
#(
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  wire logic                   req_push,
   input  wire logic [7:0]             req_dsd_byte,
   input  wire logic                   room,
   output logic                        req_full,
   output logic                        ram_wr_en,
   output logic [$clog2(MAX_BLOCK_BYTES/2)-1:0] ram_wr_addr,
   output logic [7:0]                  ram_wr_data,
   output logic                        ram_rd_en,
   output logic [$clog2(MAX_BLOCK_BYTES/2)-1:0] ram_rd_addr_a,
   output logic [$clog2(MAX_BLOCK_BYTES/2)-1:0] ram_rd_addr_b,
   output logic                        pair_valid,
   output dsdp_pair_type               pair
);

   localparam int POS_W  = $clog2(MAX_BLOCK_BYTES);
   localparam int SIZE_W = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int AW     = SIZE_W + 1;
   localparam int ADDR_W = $clog2(MAX_BLOCK_BYTES / 2);
   localparam int CW     = (SIZE_W > CSR_DATA_W) ? SIZE_W : CSR_DATA_W;
   localparam int RESET_SIZE =
      (BLOCK_BYTES_RESET > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : BLOCK_BYTES_RESET;

   logic              interleaved_ff, interleaved_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] half_ff, half_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              marker_ff, marker_in;
   logic [23:0]       held_ff, held_in;
   logic              pair_valid_ff, pair_valid_in;
   dsdp_pair_type     pair_ff, pair_in;

   logic          accept;
   logic [CW-1:0] blk_ext;
   logic [CW-1:0] blk_clamped;
   logic [AW-1:0] size_ext, half_ext, p_w, q_w, i_w, pos_next;
   logic          marker_now;
   logic          emit;
   logic [1:0]    k;

   assign accept   = req_push && room;
   assign req_full = !room;

   // Configuration: the clamped block size and its half are kept ready.
   always_comb begin
      interleaved_in = interleaved_ff;
      size_in        = size_ff;
      half_in        = half_ff;
      blk_ext        = CW'(csr_wr_data);
      if (blk_ext < CW'(BLOCK_BYTES_MIN)) begin
         blk_clamped = CW'(BLOCK_BYTES_MIN);
      end else if (blk_ext > CW'(MAX_BLOCK_BYTES)) begin
         blk_clamped = CW'(MAX_BLOCK_BYTES);
      end else begin
         blk_clamped = blk_ext;
      end
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INTERLEAVED: begin
               interleaved_in = csr_wr_data[0];
            end
            CSR_BLOCK_BYTES: begin
               size_in = SIZE_W'(blk_clamped);
               half_in = SIZE_W'(blk_clamped >> 1);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      size_ext = AW'(size_ff);
      half_ext = AW'(half_ff);
      // A position left beyond a shrunken block starts a new block.
      p_w = (AW'(pos_ff) >= size_ext) ? '0 : AW'(pos_ff);
      q_w = p_w - half_ext;
      i_w = q_w - AW'(1);
      k   = p_w[1:0];
      marker_now = (p_w == '0) ? 1'b0 : marker_ff;

      held_in       = held_ff;
      emit          = 1'b0;
      pair_in       = pair_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ADDR_W'(p_w);
      ram_wr_data   = req_dsd_byte;
      ram_rd_en     = 1'b0;
      ram_rd_addr_a = ADDR_W'(i_w);
      ram_rd_addr_b = ADDR_W'(i_w + AW'(1));

      if (interleaved_ff) begin
         if (k != 2'd3) begin
            held_in[8*k +: 8] = req_dsd_byte;
         end else begin
            emit           = 1'b1;
            pair_in.planar = 1'b0;
            pair_in.left0  = held_ff[7:0];
            pair_in.right0 = held_ff[15:8];
            pair_in.left1  = held_ff[23:16];
            pair_in.right1 = req_dsd_byte;
            pair_in.last   = (p_w + AW'(4)) >= size_ext;
         end
      end else begin
         if (p_w < half_ext) begin
            ram_wr_en = accept;
         end else if (!q_w[0]) begin
            held_in = {16'h0000, req_dsd_byte};
         end else if (q_w < half_ext) begin
            // Left bytes are read now and merged when the data returns.
            emit           = 1'b1;
            ram_rd_en      = accept;
            pair_in.planar = 1'b1;
            pair_in.left0  = 8'h00;
            pair_in.left1  = 8'h00;
            pair_in.right0 = rev8(held_ff[7:0]);
            pair_in.right1 = rev8(req_dsd_byte);
            pair_in.last   = (q_w + AW'(2)) >= half_ext;
         end
      end
      pair_in.marker = marker_now;

      pos_next  = p_w + AW'(1);
      pos_in    = (pos_next >= size_ext) ? '0 : POS_W'(pos_next);
      marker_in = marker_now ^ emit;
      pair_valid_in = accept && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interleaved_ff <= 1'b0;
         size_ff        <= SIZE_W'(RESET_SIZE);
         half_ff        <= SIZE_W'(RESET_SIZE / 2);
         pos_ff         <= '0;
         marker_ff      <= 1'b0;
         held_ff        <= '0;
         pair_valid_ff  <= 1'b0;
      end else begin
         interleaved_ff <= interleaved_in;
         size_ff        <= size_in;
         half_ff        <= half_in;
         pair_valid_ff  <= pair_valid_in;
         if (accept) begin
            pos_ff    <= pos_in;
            marker_ff <= marker_in;
            held_ff   <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pair_valid_in) begin
         pair_ff <= pair_in;
      end
   end

   assign pair_valid = pair_valid_ff;
   assign pair       = pair_ff;

endmodule
`default_nettype wire

// ===== src/dsdp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsdp_back
// Completes frame pairs with the store read data, queues them and delivers
// each pair as a left frame followed by a right frame.
// ----------------------------------------------------------------------------
module dsdp_back
   import dsdp_pkg::*;
#(
   parameter int DEPTH = PAIR_QUEUE_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          pair_valid,
   input  wire dsdp_pair_type pair,
   input  wire logic [7:0]    rd_data_a,
   input  wire logic [7:0]    rd_data_b,
   output logic               room,
   input  wire logic          rsp_pop,
   output logic               rsp_empty,
   output logic [31:0]        rsp_dop_word,
   output logic               rsp_right_channel,
   output logic               rsp_last
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dsdp_pair_type    queue_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             side_ff, side_in;

   dsdp_pair_type entry;
   dsdp_pair_type head;
   logic          take;
   logic          release_pair;
   logic [7:0]    marker_byte;

   always_comb begin
      entry = pair;
      if (pair.planar) begin
         entry.left0 = rev8(rd_data_a);
         entry.left1 = rev8(rd_data_b);
      end
   end

   assign head         = queue_ff[rd_ptr_ff];
   assign take         = rsp_pop && !rsp_empty;
   assign release_pair = take && side_ff;
   // Counts the pair still in the front stage so nothing can overflow.
   assign room = (CNT_W'(count_ff) + CNT_W'(pair_valid)) < CNT_W'(DEPTH);

   always_comb begin
      wr_ptr_in = pair_valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = release_pair ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(pair_valid) - CNT_W'(release_pair);
      side_in   = take ? !side_ff : side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         side_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         side_ff   <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair_valid) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   assign marker_byte       = head.marker ? MARKER_FLIP : MARKER_BASE;
   assign rsp_empty         = (count_ff == '0);
   assign rsp_right_channel = side_ff;
   assign rsp_last          = side_ff && head.last;
   assign rsp_dop_word      = side_ff ? {marker_byte, head.right0, head.right1, 8'h00}
                                      : {marker_byte, head.left0, head.left1, 8'h00};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("pair queue count exceeds its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pair_valid |-> (count_ff < CNT_W'(DEPTH)))
      else $error("pair arrived while the queue was full");

   a_right_follows_left: assert property (@(posedge clock) disable iff (reset)
      (take && !side_ff) |=> (!rsp_empty && side_ff))
      else $error("left frame not followed by its right frame");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (release_pair && count_ff == CNT_W'(1) && !pair_valid) |=> rsp_empty)
      else $error("queue not empty after its last pair left");

endmodule
`default_nettype wire

// ===== src/dsd_to_dop_packer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_to_dop_packer_core
// Packs stereo DSD bytes into 32-bit DoP frames.
// ----------------------------------------------------------------------------
// The block takes one DSD byte per clock cycle while req_full is low and
// delivers one DoP frame per cycle while rsp_pop is high and rsp_empty is
// low; a left/right pair of frames is queued as one entry, with room for
// four pairs, so a steady byte stream does not stall while the receiver
// keeps popping. In planar mode the left half of each block is written to
// an on-chip store of MAX_BLOCK_BYTES/2 bytes, and a right pair reads two
// left bytes from it. Pairs are registered in the front end, then queued.
// The store needs no clearing after reset, so bytes are accepted at once.
// Configuration must be written by the user while idle; it is not enforced.
// ----------------------------------------------------------------------------
module dsd_to_dop_packer_core
   import dsdp_pkg::*;
#(
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   input  wire logic                  req_push,
   input  wire logic [7:0]            req_dsd_byte,
   output logic                       req_full,
   input  wire logic                  rsp_pop,
   output logic                       rsp_empty,
   output logic [31:0]                rsp_dop_word,
   output logic                       rsp_right_channel,
   output logic                       rsp_last
);

   localparam int STORE_DEPTH = MAX_BLOCK_BYTES / 2;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   logic              room;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr_a;
   logic [ADDR_W-1:0] ram_rd_addr_b;
   logic [7:0]        ram_rd_data_a;
   logic [7:0]        ram_rd_data_b;
   logic              pair_valid;
   dsdp_pair_type     pair;

   dsdp_front #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_push      (req_push),
      .req_dsd_byte  (req_dsd_byte),
      .room          (room),
      .req_full      (req_full),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr_a (ram_rd_addr_a),
      .ram_rd_addr_b (ram_rd_addr_b),
      .pair_valid    (pair_valid),
      .pair          (pair)
   );

   dsdp_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   dsdp_back #(
      .DEPTH (PAIR_QUEUE_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pair_valid        (pair_valid),
      .pair              (pair),
      .rd_data_a         (ram_rd_data_a),
      .rd_data_b         (ram_rd_data_b),
      .room              (room),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_dop_word      (rsp_dop_word),
      .rsp_right_channel (rsp_right_channel),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

// ===== sim/dsd_to_dop_packer_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsd_to_dop_packer_core_tb
// Self-checking bench for the DSD to DoP packer core. A clocked driver pushes
// DSD bytes from a queue filled by the stimulus process. A clocked monitor
// tracks register writes and accepted bytes in its own packer model, and it
// checks every popped frame against the oldest frame still due. Directed
// cases come first, then random phases with a fresh setting each.
// ----------------------------------------------------------------------------
module dsd_to_dop_packer_core_tb
   import dsdp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STORE_BYTES  = MAX_BLOCK_BYTES_DEF / 2;
   localparam int unsigned RANDOM_ITEMS = 950;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned HOLD_PHASE   = 2;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned MAX_REPORTS  = 50;

   typedef struct packed {
      logic [31:0] word;
      logic        right;
      logic        last;
   } dop_frame_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_INTERLEAVED;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  req_push = 1'b0;
   logic [7:0]            req_dsd_byte = 8'h00;
   logic                  req_full;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_empty;
   logic [31:0]           rsp_dop_word;
   logic                  rsp_right_channel;
   logic                  rsp_last;

   // Stimulus and idling control.
   logic [7:0]  byte_q[$];
   int unsigned tx_gap = 0;
   int unsigned rx_gap = 0;
   int unsigned tx_idle_max = 0;
   int unsigned rx_idle_max = 0;
   int unsigned bytes_fed = 0;
   int unsigned cycle_count = 0;
   int unsigned fault_count = 0;
   logic        rsp_hold = 1'b0;
   bit          hold_go = 1'b0;

   // Packer model: configuration, block state and the frames still due.
   logic          cfg_interleaved;
   logic [13:0]   cfg_block;
   int unsigned   blk_pos;
   logic          marker_alt;
   logic [23:0]   partial;
   logic [7:0]    left_bytes [STORE_BYTES];
   dop_frame_type frames_due[$];

   dsd_to_dop_packer_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_push          (req_push),
      .req_dsd_byte      (req_dsd_byte),
      .req_full          (req_full),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_dop_word      (rsp_dop_word),
      .rsp_right_channel (rsp_right_channel),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] mirror8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = b[7-i];
      return r;
   endfunction

   function automatic int unsigned active_block();
      if (cfg_block < BLOCK_BYTES_MIN) return BLOCK_BYTES_MIN;
      if (cfg_block > MAX_BLOCK_BYTES_DEF) return MAX_BLOCK_BYTES_DEF;
      return cfg_block;
   endfunction

   function automatic logic [31:0] dop_frame(input logic [7:0] first, input logic [7:0] second);
      return {marker_alt ? MARKER_FLIP : MARKER_BASE, first, second, 8'h00};
   endfunction

   function automatic void queue_pair(input logic [7:0] l0, input logic [7:0] l1,
                                      input logic [7:0] r0, input logic [7:0] r1,
                                      input logic last);
      frames_due.push_back('{word: dop_frame(l0, l1), right: 1'b0, last: 1'b0});
      frames_due.push_back('{word: dop_frame(r0, r1), right: 1'b1, last: last});
      marker_alt = ~marker_alt;
   endfunction

   function automatic void pack_byte(input logic [7:0] b);
      int unsigned sz;
      int unsigned p;
      int unsigned half;
      int unsigned q;
      int unsigned k;
      sz = active_block();
      // A block that shrank under the current position starts over.
      if (blk_pos >= sz) blk_pos = 0;
      p = blk_pos;
      if (p == 0) marker_alt = 1'b0;
      if (cfg_interleaved) begin
         k = p % 4;
         if (k < 3) begin
            partial[8*k +: 8] = b;
         end else begin
            queue_pair(partial[7:0], partial[23:16], partial[15:8], b, p + 4 >= sz);
         end
      end else begin
         half = sz / 2;
         if (p < half) begin
            left_bytes[p] = b;
         end else begin
            q = p - half;
            if (q % 2 == 0) begin
               partial = {16'h0000, b};
            end else if (q < half) begin
               queue_pair(mirror8(left_bytes[q-1]), mirror8(left_bytes[q]),
                          mirror8(partial[7:0]), mirror8(b), q + 2 >= half);
            end
         end
      end
      blk_pos = p + 1;
      if (blk_pos >= sz) blk_pos = 0;
   endfunction

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, what, want, got);
   endtask

   always @(posedge clock) begin : driver
      int unsigned g;
      if (reset) begin
         req_push <= 1'b0;
         tx_gap <= 0;
      end else if (!req_push || !req_full) begin
         // A gap is drawn each time an item goes in.
         g = req_push ? $urandom_range(0, tx_idle_max) : tx_gap;
         if (g == 0 && byte_q.size() != 0) begin
            req_dsd_byte <= byte_q.pop_front();
            req_push <= 1'b1;
            tx_gap <= 0;
         end else begin
            req_push <= 1'b0;
            tx_gap <= (g != 0) ? g - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      int unsigned g;
      dop_frame_type due;
      if (reset) begin
         cfg_interleaved = 1'b0;
         cfg_block = BLOCK_BYTES_RESET;
         blk_pos = 0;
         marker_alt = 1'b0;
         partial = '0;
         rsp_pop <= 1'b0;
         rx_gap <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_INTERLEAVED) cfg_interleaved = csr_wr_data[0];
            else if (csr_index == CSR_BLOCK_BYTES) cfg_block = csr_wr_data;
         end
         if (req_push && !req_full) pack_byte(req_dsd_byte);
         g = rx_gap;
         if (rsp_pop && !rsp_empty) begin
            if (frames_due.size() == 0) begin
               report("unexpected frame", 32'h0, rsp_dop_word);
            end else begin
               due = frames_due.pop_front();
               if (rsp_dop_word !== due.word) report("dop_word", due.word, rsp_dop_word);
               if (rsp_right_channel !== due.right)
                  report("right_channel", due.right, rsp_right_channel);
               if (rsp_last !== due.last) report("last", due.last, rsp_last);
            end
            g = $urandom_range(0, rx_idle_max);
         end
         if (g != 0) begin
            rsp_pop <= 1'b0;
            rx_gap <= g - 1;
         end else begin
            rsp_pop <= !rsp_hold;
            rx_gap <= 0;
         end
      end
   end

   // Long receiver stall so that the output queue fills and req_full rises.
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic feed_rand(input int unsigned n);
      repeat (n) byte_q.push_back(8'($urandom_range(0, 255)));
      bytes_fed += n;
   endtask

   // Pushes the n low bytes of vals, most significant first.
   task automatic feed_word(input logic [63:0] vals, input int unsigned n);
      for (int i = n - 1; i >= 0; i--) byte_q.push_back(vals[8*i +: 8]);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (byte_q.size() != 0 || req_push || frames_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Leaves the block at a block boundary, so that planar right pairs only
   // read store entries that were written.
   task automatic close_phase();
      int unsigned sz;
      wait_idle();
      sz = active_block();
      if (blk_pos != 0 && blk_pos < sz) begin
         if (blk_pos >= BLOCK_BYTES_MIN) begin
            write_reg(CSR_BLOCK_BYTES, BLOCK_BYTES_MIN);
            feed_rand(BLOCK_BYTES_MIN);
         end else begin
            feed_rand(sz - blk_pos);
         end
         wait_idle();
      end
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned blk;
      int unsigned n;
      int unsigned big_left;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Block size below the minimum acts as four.
      write_reg(CSR_INTERLEAVED, 1);
      write_reg(CSR_BLOCK_BYTES, 0);
      feed_word(64'h00FF_FF00, 4);
      close_phase();

      // Planar block of eight: bit reversal and a marker flip.
      write_reg(CSR_INTERLEAVED, 0);
      write_reg(CSR_BLOCK_BYTES, 8);
      feed_word(64'h0180_0FF0_55AA_33CC, 8);
      close_phase();

      // Odd planar block of seven: the last two right bytes are dropped.
      write_reg(CSR_BLOCK_BYTES, 7);
      feed_rand(7);
      close_phase();

      // Interleaved block of six: two trailing bytes are dropped.
      write_reg(CSR_INTERLEAVED, 1);
      write_reg(CSR_BLOCK_BYTES, 6);
      feed_rand(6);
      close_phase();

      // Interleaved to planar in the middle of a block.
      write_reg(CSR_BLOCK_BYTES, 8);
      feed_word(64'hC3_3C, 2);
      wait_idle();
      write_reg(CSR_INTERLEAVED, 0);
      feed_rand(6);
      close_phase();

      // Planar to interleaved in the middle of a block.
      feed_rand(5);
      wait_idle();
      write_reg(CSR_INTERLEAVED, 1);
      feed_rand(3);
      close_phase();

      // Oversized block, then a shrink below the current position.
      write_reg(CSR_BLOCK_BYTES, 16383);
      feed_rand(5);
      wait_idle();
      write_reg(CSR_BLOCK_BYTES, BLOCK_BYTES_MIN);
      feed_rand(4);
      close_phase();

      bytes_fed = 0;
      phase = 0;
      big_left = 3;
      while (bytes_fed < RANDOM_ITEMS) begin
         tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
         rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
         case ($urandom_range(0, 9))
            0: blk = $urandom_range(0, BLOCK_BYTES_MIN - 1);
            1: blk = BLOCK_BYTES_MIN;
            2: begin
               if (big_left != 0) begin
                  big_left--;
                  blk = $urandom_range(0, 1) ? MAX_BLOCK_BYTES_DEF
                                             : $urandom_range(MAX_BLOCK_BYTES_DEF + 1, 16383);
               end else begin
                  blk = $urandom_range(BLOCK_BYTES_MIN, 48);
               end
            end
            default: blk = $urandom_range(BLOCK_BYTES_MIN, 48);
         endcase
         write_reg(CSR_INTERLEAVED, $urandom_range(0, 1));
         write_reg(CSR_BLOCK_BYTES, blk);
         n = $urandom_range(10, 80);
         if (phase == HOLD_PHASE) begin
            // Interleaved input yields a pair from each full group of four bytes in a block.
            write_reg(CSR_INTERLEAVED, 1);
            n = 200;
            tx_idle_max = 0;
            hold_go = 1'b1;
         end
         feed_rand(n);
         close_phase();
         phase++;
      end

      wait_idle();
      if (fault_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire

// ===== dsd_to_dop_packer_core.f =====
src/dsdp_pkg.sv
src/dsdp_ram.sv
src/dsdp_front.sv
src/dsdp_back.sv
src/dsd_to_dop_packer_core.sv
sim/dsd_to_dop_packer_core_tb.sv
